### src/bwbp_pkg.sv
// ----------------------------------------------------------------------------
// bwbp_pkg: shared types and constants
// Widths, register indexes, reset values and fixed-point constants used by
// the band-pass mask pipeline.
// ----------------------------------------------------------------------------
package bwbp_pkg;

  // payload and configuration port widths
  localparam int COORD_W = 12;
  localparam int GAIN_W  = 16;
  localparam int CFG_DW  = 24;
  localparam int CFG_IW  = 3;

  // register field widths
  localparam int SIZE_W  = 13;
  localparam int SPACE_W = 24;
  localparam int CUT_W   = 20;
  localparam int ORDER_W = 5;

  // arithmetic widths
  localparam int Q_W    = 32;            // ratio, power and frequency words
  localparam int S_W    = 64;            // squared radial frequency
  localparam int F2_W   = 2 * CUT_W + 8; // squared cutoff in 2^-32 units
  localparam int TDEN_W = 33;            // 1 + a^n in Q16
  localparam int TERM_W = 17;            // term in Q16, up to 1.0
  localparam int PROD_W = 2 * TERM_W;

  // register indexes
  typedef enum logic [CFG_IW-1:0] {
    REG_SIZE_U    = 3'd0,
    REG_SIZE_V    = 3'd1,
    REG_SPACING_U = 3'd2,
    REG_SPACING_V = 3'd3,
    REG_CUT_LOW   = 3'd4,
    REG_CUT_HIGH  = 3'd5,
    REG_ORDER     = 3'd6
  } cfg_reg_t;

  // reset values
  localparam logic [SIZE_W-1:0]  RST_SIZE     = 13'd256;
  localparam logic [SPACE_W-1:0] RST_SPACING  = 24'd65536;
  localparam logic [CUT_W-1:0]   RST_CUT_LOW  = 20'd410;
  localparam logic [CUT_W-1:0]   RST_CUT_HIGH = 20'd2048;
  localparam logic [ORDER_W-1:0] RST_ORDER    = 5'd2;

  // fixed-point constants
  localparam logic [Q_W-1:0]    P_ONE     = 32'h0001_0000;
  localparam logic [Q_W-1:0]    UV_SAT    = 32'h8000_0000;
  localparam logic [TDEN_W-1:0] TDEN_ONE  = 33'h0_0001_0000;
  localparam logic [TDEN_W-1:0] TREM_INIT = 33'h0_0000_8000;
  localparam logic [TERM_W-1:0] TERM_HALF = 17'h0_8000;
  localparam logic [GAIN_W-1:0] GAIN_MAX  = 16'hFFFF;

  // flags that ride along a ratio divider
  typedef struct packed {
    logic sat;     // ratio too large
    logic zero;    // zero over zero, ratio is 0
    logic centre;  // grid centre, term forced to 0
  } ratio_flag_t;

endpackage

### src/bwbp_in_if.sv
// ----------------------------------------------------------------------------
// bwbp_in_if: coordinate channel
// Valid/ready channel carrying one pixel coordinate per beat.
// ----------------------------------------------------------------------------
interface bwbp_in_if;
  logic                           valid;
  logic                           ready;
  logic [bwbp_pkg::COORD_W-1:0]   coord_x;
  logic [bwbp_pkg::COORD_W-1:0]   coord_y;

  modport source (output valid, output coord_x, output coord_y, input ready);
  modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface

### src/bwbp_out_if.sv
// ----------------------------------------------------------------------------
// bwbp_out_if: gain channel
// Valid/ready channel carrying one Q0.16 gain per beat.
// ----------------------------------------------------------------------------
interface bwbp_out_if;
  logic                          valid;
  logic                          ready;
  logic [bwbp_pkg::GAIN_W-1:0]   gain;

  modport source (output valid, output gain, input ready);
  modport sink   (input valid, input gain, output ready);
endinterface

### src/butterworth_bandpass_mask.sv
// ----------------------------------------------------------------------------
// butterworth_bandpass_mask: Butterworth band-pass gain per grid pixel
// Maps a pixel coordinate to H = HP * LP in Q0.16 through a fully
// pipelined chain of dividers and multipliers.
//
//   channel  dir  payload                 handshake
//   in_ch    in   coord_x[12], coord_y[12] valid/ready
//   out_ch   out  gain[16]                 valid/ready
//   cfg_*    in   cfg_idx[3], cfg_data[24] write enable only
//
// one beat enters per cycle unless the pipe is held; the path runs through the
// 32-stage frequency and ratio dividers, the MAX_ORDER power stages and the
// 17-stage term divider. reset is synchronous and loads the register
// defaults. the whole pipe holds while a two-entry output buffer is full,
// so in_ch.ready comes from a register and never from out_ch.ready.
// ----------------------------------------------------------------------------
module butterworth_bandpass_mask #(
  parameter int MAX_DIM   = 4096,
  parameter int MAX_ORDER = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bwbp_in_if.sink                       in_ch,
  bwbp_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [bwbp_pkg::CFG_IW-1:0]   cfg_idx,
  input  logic [bwbp_pkg::CFG_DW-1:0]   cfg_data
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int MAG_W  = (DIM_W > bwbp_pkg::COORD_W) ? DIM_W : bwbp_pkg::COORD_W;
  localparam int DEN_W  = DIM_W + bwbp_pkg::SPACE_W;
  localparam int ORD_W  = $clog2(MAX_ORDER + 1);
  localparam int QW     = bwbp_pkg::Q_W;
  localparam int SW     = bwbp_pkg::S_W;
  localparam int F2W    = bwbp_pkg::F2_W;
  localparam int TW     = bwbp_pkg::TERM_W;
  localparam int TDW    = bwbp_pkg::TDEN_W;
  localparam int FLAG_W = $bits(bwbp_pkg::ratio_flag_t);

  // configuration registers
  logic [bwbp_pkg::SIZE_W-1:0]  size_u_r, size_v_r;
  logic [bwbp_pkg::SPACE_W-1:0] spacing_u_r, spacing_v_r;
  logic [bwbp_pkg::CUT_W-1:0]   cut_low_r, cut_high_r;
  logic [bwbp_pkg::ORDER_W-1:0] order_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_u_r    <= bwbp_pkg::RST_SIZE;
      size_v_r    <= bwbp_pkg::RST_SIZE;
      spacing_u_r <= bwbp_pkg::RST_SPACING;
      spacing_v_r <= bwbp_pkg::RST_SPACING;
      cut_low_r   <= bwbp_pkg::RST_CUT_LOW;
      cut_high_r  <= bwbp_pkg::RST_CUT_HIGH;
      order_r     <= bwbp_pkg::RST_ORDER;
    end else if (cfg_we) begin
      unique case (bwbp_pkg::cfg_reg_t'(cfg_idx))
        bwbp_pkg::REG_SIZE_U:    size_u_r    <= cfg_data[bwbp_pkg::SIZE_W-1:0];
        bwbp_pkg::REG_SIZE_V:    size_v_r    <= cfg_data[bwbp_pkg::SIZE_W-1:0];
        bwbp_pkg::REG_SPACING_U: spacing_u_r <= cfg_data[bwbp_pkg::SPACE_W-1:0];
        bwbp_pkg::REG_SPACING_V: spacing_v_r <= cfg_data[bwbp_pkg::SPACE_W-1:0];
        bwbp_pkg::REG_CUT_LOW:   cut_low_r   <= cfg_data[bwbp_pkg::CUT_W-1:0];
        bwbp_pkg::REG_CUT_HIGH:  cut_high_r  <= cfg_data[bwbp_pkg::CUT_W-1:0];
        bwbp_pkg::REG_ORDER:     order_r     <= cfg_data[bwbp_pkg::ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // values derived from the registers
  logic [DIM_W-1:0]           su_clamp, sv_clamp;
  logic [DEN_W-1:0]           den_u_raw, den_v_raw;
  logic [2*bwbp_pkg::CUT_W-1:0] fh_sq, fl_sq;
  logic [ORD_W-1:0]           ord_clamp;
  logic [DEN_W-1:0]           den_u_r, den_v_r;
  logic [F2W-1:0]             fh2_r, fl2_r;
  logic [ORD_W-1:0]           ord_r;
  logic                       ord_zero;

  assign su_clamp  = (32'(size_u_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(size_u_r);
  assign sv_clamp  = (32'(size_v_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(size_v_r);
  assign den_u_raw = DEN_W'(su_clamp) * DEN_W'(spacing_u_r);
  assign den_v_raw = DEN_W'(sv_clamp) * DEN_W'(spacing_v_r);
  assign fh_sq     = (2*bwbp_pkg::CUT_W)'(cut_high_r) * (2*bwbp_pkg::CUT_W)'(cut_high_r);
  assign fl_sq     = (2*bwbp_pkg::CUT_W)'(cut_low_r) * (2*bwbp_pkg::CUT_W)'(cut_low_r);
  assign ord_clamp = (32'(order_r) > MAX_ORDER) ? ORD_W'(MAX_ORDER) : ORD_W'(order_r);
  assign ord_zero  = (ord_r == '0);

  always_ff @(posedge clk) begin
    den_u_r <= (den_u_raw == '0) ? DEN_W'(1) : den_u_raw;
    den_v_r <= (den_v_raw == '0) ? DEN_W'(1) : den_v_raw;
    fh2_r   <= {fh_sq, 8'h00};
    fl2_r   <= {fl_sq, 8'h00};
    ord_r   <= ord_clamp;
  end

  // pipe advances unless the output buffer is full
  logic en;
  logic out_vld_r, skid_vld_r;
  logic [bwbp_pkg::GAIN_W-1:0] out_gain_r, skid_gain_r;

  assign en          = !skid_vld_r;
  assign in_ch.ready = en;

  // stage a: distance from centre
  logic [MAG_W-1:0] xw, yw, hu, hv, mag_x, mag_y;
  logic             a_vld_r, a_cen_r;
  logic [MAG_W-1:0] a_magx_r, a_magy_r;

  assign xw    = MAG_W'(in_ch.coord_x);
  assign yw    = MAG_W'(in_ch.coord_y);
  assign hu    = MAG_W'(su_clamp >> 1);
  assign hv    = MAG_W'(sv_clamp >> 1);
  assign mag_x = (xw >= hu) ? xw - hu : hu - xw;
  assign mag_y = (yw >= hv) ? yw - hv : hv - yw;

  // stage b: saturation check against the scale
  logic             b_vld_r, b_cen_r, b_satx_r, b_saty_r;
  logic [MAG_W-1:0] b_magx_r, b_magy_r;

  // stage c: clamped frequencies
  logic          du_vld, dv_vld;
  logic [QW-1:0] du_quo, dv_quo;
  logic [1:0]    du_side;
  logic          dv_side;
  logic          c_vld_r, c_cen_r;
  logic [QW-1:0] c_u_r, c_v_r;

  // stages d, e: squares and sum
  logic          d_vld_r, d_cen_r, e_vld_r, e_cen_r;
  logic [SW-1:0] d_uu_r, d_vv_r, e_s_r;

  // stage f: ratio setup
  logic                  lp_den0, hp_s0;
  bwbp_pkg::ratio_flag_t lp_flag, hp_flag;
  logic                  f_vld_r;
  logic [F2W-1:0]        f_lp_rem_r;
  logic [QW-1:0]         f_lp_feed_r, f_hp_feed_r;
  logic [SW-1:0]         f_hp_rem_r, f_hp_den_r;
  bwbp_pkg::ratio_flag_t f_lp_flag_r, f_hp_flag_r;

  assign lp_den0        = (fh2_r == '0);
  assign lp_flag.sat    = lp_den0 ? (e_s_r != '0) : (e_s_r[SW-1:16] >= fh2_r);
  assign lp_flag.zero   = lp_den0 && (e_s_r == '0);
  assign lp_flag.centre = 1'b0;
  assign hp_s0          = (e_s_r == '0);
  assign hp_flag.sat    = hp_s0 ? (fl2_r != '0) : (SW'(fl2_r[F2W-1:16]) >= e_s_r);
  assign hp_flag.zero   = hp_s0 && (fl2_r == '0);
  assign hp_flag.centre = e_cen_r;

  // ratio dividers out, power lanes in
  logic                  rl_vld, rh_vld;
  logic [QW-1:0]         rl_quo, rh_quo;
  logic [FLAG_W-1:0]     rl_side, rh_side;
  bwbp_pkg::ratio_flag_t rl_f, rh_f;
  logic [QW-1:0]         pl_a, ph_a;
  logic                  pl_kill_in, ph_kill_in;

  assign rl_f       = bwbp_pkg::ratio_flag_t'(rl_side);
  assign rh_f       = bwbp_pkg::ratio_flag_t'(rh_side);
  assign pl_a       = rl_f.zero ? '0 : rl_quo;
  assign ph_a       = rh_f.zero ? '0 : rh_quo;
  assign pl_kill_in = rl_f.centre || (rl_f.sat && !ord_zero);
  assign ph_kill_in = rh_f.centre || (rh_f.sat && !ord_zero);

  // stage g: term divisors
  logic           pl_vld, ph_vld, pl_kill, ph_kill;
  logic [QW-1:0]  pl_p, ph_p;
  logic           g_vld_r, g_lp_kill_r, g_hp_kill_r;
  logic [TDW-1:0] g_lp_den_r, g_hp_den_r;

  // stages h, i: terms and product
  logic          tl_vld, th_vld, tl_side, th_side;
  logic [TW-1:0] tl_quo, th_quo;
  logic          h_vld_r, i_vld_r;
  logic [TW-1:0] h_lp_r, h_hp_r;
  logic [bwbp_pkg::PROD_W-1:0] i_prod_r;
  logic [bwbp_pkg::GAIN_W-1:0] fin_gain;
  logic          push;

  // valid bits of the register stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
      g_vld_r <= 1'b0;
      h_vld_r <= 1'b0;
      i_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_ch.valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= du_vld;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
      f_vld_r <= e_vld_r;
      g_vld_r <= pl_vld;
      h_vld_r <= tl_vld;
      i_vld_r <= h_vld_r;
    end
  end

  // payload of the register stages
  always_ff @(posedge clk) begin
    if (en) begin
      a_magx_r    <= mag_x;
      a_magy_r    <= mag_y;
      a_cen_r     <= (xw == hu) && (yw == hv);

      b_magx_r    <= a_magx_r;
      b_magy_r    <= a_magy_r;
      b_satx_r    <= (DEN_W'(a_magx_r) >= den_u_r);
      b_saty_r    <= (DEN_W'(a_magy_r) >= den_v_r);
      b_cen_r     <= a_cen_r;

      c_u_r       <= (du_side[0] || du_quo > bwbp_pkg::UV_SAT) ? bwbp_pkg::UV_SAT : du_quo;
      c_v_r       <= (dv_side || dv_quo > bwbp_pkg::UV_SAT) ? bwbp_pkg::UV_SAT : dv_quo;
      c_cen_r     <= du_side[1];

      d_uu_r      <= SW'(c_u_r) * SW'(c_u_r);
      d_vv_r      <= SW'(c_v_r) * SW'(c_v_r);
      d_cen_r     <= c_cen_r;

      e_s_r       <= d_uu_r + d_vv_r;
      e_cen_r     <= d_cen_r;

      f_lp_rem_r  <= e_s_r[SW-1:16];
      f_lp_feed_r <= {e_s_r[15:0], 16'h0000};
      f_hp_rem_r  <= SW'(fl2_r[F2W-1:16]);
      f_hp_feed_r <= {fl2_r[15:0], 16'h0000};
      f_hp_den_r  <= e_s_r;
      f_lp_flag_r <= lp_flag;
      f_hp_flag_r <= hp_flag;

      g_lp_den_r  <= TDW'(pl_p) + bwbp_pkg::TDEN_ONE;
      g_hp_den_r  <= TDW'(ph_p) + bwbp_pkg::TDEN_ONE;
      g_lp_kill_r <= pl_kill;
      g_hp_kill_r <= ph_kill;

      h_lp_r      <= tl_side ? '0 : (ord_zero ? bwbp_pkg::TERM_HALF : tl_quo);
      h_hp_r      <= th_side ? '0 : (ord_zero ? bwbp_pkg::TERM_HALF : th_quo);

      i_prod_r    <= bwbp_pkg::PROD_W'(h_hp_r) * bwbp_pkg::PROD_W'(h_lp_r);
    end
  end

  // frequency dividers: |d| * 2^32 / (size * spacing)
  bwbp_div #(.DW(DEN_W), .QW(QW), .SW(2)) u_div_u (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(b_vld_r), .in_rem(DEN_W'(b_magx_r)), .in_feed('0),
    .in_den(den_u_r), .in_side({b_cen_r, b_satx_r}),
    .out_valid(du_vld), .out_quo(du_quo), .out_side(du_side)
  );

  bwbp_div #(.DW(DEN_W), .QW(QW), .SW(1)) u_div_v (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(b_vld_r), .in_rem(DEN_W'(b_magy_r)), .in_feed('0),
    .in_den(den_v_r), .in_side(b_saty_r),
    .out_valid(dv_vld), .out_quo(dv_quo), .out_side(dv_side)
  );

  // ratio dividers: S / Fh^2 and Fl^2 / S in Q16
  bwbp_div #(.DW(F2W), .QW(QW), .SW(FLAG_W)) u_div_lp (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(f_vld_r), .in_rem(f_lp_rem_r), .in_feed(f_lp_feed_r),
    .in_den(fh2_r), .in_side(f_lp_flag_r),
    .out_valid(rl_vld), .out_quo(rl_quo), .out_side(rl_side)
  );

  bwbp_div #(.DW(SW), .QW(QW), .SW(FLAG_W)) u_div_hp (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(f_vld_r), .in_rem(f_hp_rem_r), .in_feed(f_hp_feed_r),
    .in_den(f_hp_den_r), .in_side(f_hp_flag_r),
    .out_valid(rh_vld), .out_quo(rh_quo), .out_side(rh_side)
  );

  // power lanes
  bwbp_pow #(.MAX_ORDER(MAX_ORDER), .ORD_W(ORD_W)) u_pow_lp (
    .clk(clk), .rst_n(rst_n), .en(en), .n(ord_r),
    .in_valid(rl_vld), .in_a(pl_a), .in_kill(pl_kill_in),
    .out_valid(pl_vld), .out_p(pl_p), .out_kill(pl_kill)
  );

  bwbp_pow #(.MAX_ORDER(MAX_ORDER), .ORD_W(ORD_W)) u_pow_hp (
    .clk(clk), .rst_n(rst_n), .en(en), .n(ord_r),
    .in_valid(rh_vld), .in_a(ph_a), .in_kill(ph_kill_in),
    .out_valid(ph_vld), .out_p(ph_p), .out_kill(ph_kill)
  );

  // term dividers: 2^32 / (1 + a^n)
  bwbp_div #(.DW(TDW), .QW(TW), .SW(1)) u_div_tlp (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(g_vld_r), .in_rem(bwbp_pkg::TREM_INIT), .in_feed('0),
    .in_den(g_lp_den_r), .in_side(g_lp_kill_r),
    .out_valid(tl_vld), .out_quo(tl_quo), .out_side(tl_side)
  );

  bwbp_div #(.DW(TDW), .QW(TW), .SW(1)) u_div_thp (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(g_vld_r), .in_rem(bwbp_pkg::TREM_INIT), .in_feed('0),
    .in_den(g_hp_den_r), .in_side(g_hp_kill_r),
    .out_valid(th_vld), .out_quo(th_quo), .out_side(th_side)
  );

  // gain with saturation at one
  assign fin_gain = (|i_prod_r[bwbp_pkg::PROD_W-1:32]) ? bwbp_pkg::GAIN_MAX
                                                        : i_prod_r[31:16];
  assign push     = en && i_vld_r;

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_ch.ready || !out_vld_r) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r  <= push;
      end
    end else if (push) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ch.ready || !out_vld_r) begin
      out_gain_r <= skid_vld_r ? skid_gain_r : fin_gain;
    end else if (push) begin
      skid_gain_r <= fin_gain;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.gain  = out_gain_r;

`ifndef SYNTH
  // paired lanes must stay in lock step
  a_uv_lock: assert property (@(posedge clk) disable iff (!rst_n) du_vld == dv_vld)
    else $error("frequency dividers out of step");
  a_ratio_lock: assert property (@(posedge clk) disable iff (!rst_n) rl_vld == rh_vld)
    else $error("ratio dividers out of step");
  a_pow_lock: assert property (@(posedge clk) disable iff (!rst_n) pl_vld == ph_vld)
    else $error("power lanes out of step");
  a_term_lock: assert property (@(posedge clk) disable iff (!rst_n) tl_vld == th_vld)
    else $error("term dividers out of step");
  // the skid entry only fills behind a held beat
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n) skid_vld_r |-> out_vld_r)
    else $error("skid entry holds a beat with empty output register");
`endif

endmodule

### src/bwbp_div.sv
// ----------------------------------------------------------------------------
// bwbp_div: pipelined restoring divider
// One quotient bit per stage. The starting remainder must be below the
// divisor; the low dividend bits enter one per stage from in_feed.
// ----------------------------------------------------------------------------
module bwbp_div #(
  parameter int DW = 32,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_feed,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic          vld_r  [QW];
  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] feed_r [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic          vld_prev;
    logic [DW-1:0] rem_prev;
    logic [QW-1:0] feed_prev;
    logic [QW-1:0] quo_prev;
    logic [DW-1:0] den_prev;
    logic [SW-1:0] side_prev;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign vld_prev  = in_valid;
      assign rem_prev  = in_rem;
      assign feed_prev = in_feed;
      assign quo_prev  = '0;
      assign den_prev  = in_den;
      assign side_prev = in_side;
    end else begin : g_next
      assign vld_prev  = vld_r[i-1];
      assign rem_prev  = rem_r[i-1];
      assign feed_prev = feed_r[i-1];
      assign quo_prev  = quo_r[i-1];
      assign den_prev  = den_r[i-1];
      assign side_prev = side_r[i-1];
    end

    // shift in next dividend bit, trial subtract
    assign trial = {rem_prev, feed_prev[QW-1]};
    assign diff  = trial - {1'b0, den_prev};
    assign ge    = (trial >= {1'b0, den_prev});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        feed_r[i] <= {feed_prev[QW-2:0], 1'b0};
        quo_r[i]  <= {quo_prev[QW-2:0], ge};
        den_r[i]  <= den_prev;
        side_r[i] <= side_prev;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

### src/bwbp_pow.sv
// ----------------------------------------------------------------------------
// bwbp_pow: pipelined Q16 power
// Stage i multiplies by the ratio when i is below the order. A product of
// 2^32 or more sets kill, after which the word is left alone.
// ----------------------------------------------------------------------------
module bwbp_pow #(
  parameter int MAX_ORDER = 16,
  parameter int ORD_W     = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [ORD_W-1:0]            n,
  input  logic                        in_valid,
  input  logic [bwbp_pkg::Q_W-1:0]    in_a,
  input  logic                        in_kill,
  output logic                        out_valid,
  output logic [bwbp_pkg::Q_W-1:0]    out_p,
  output logic                        out_kill
);

  localparam int QW = bwbp_pkg::Q_W;

  logic          vld_r  [MAX_ORDER];
  logic [QW-1:0] p_r    [MAX_ORDER];
  logic [QW-1:0] a_r    [MAX_ORDER];
  logic          kill_r [MAX_ORDER];

  for (genvar i = 0; i < MAX_ORDER; i++) begin : g_stage
    logic            vld_prev;
    logic [QW-1:0]   p_prev;
    logic [QW-1:0]   a_prev;
    logic            kill_prev;
    logic [2*QW-1:0] prod;
    logic [QW+15:0]  p_new;
    logic            act;

    if (i == 0) begin : g_first
      assign vld_prev  = in_valid;
      assign p_prev    = bwbp_pkg::P_ONE;
      assign a_prev    = in_a;
      assign kill_prev = in_kill;
    end else begin : g_next
      assign vld_prev  = vld_r[i-1];
      assign p_prev    = p_r[i-1];
      assign a_prev    = a_r[i-1];
      assign kill_prev = kill_r[i-1];
    end

    // one Q16 multiply per stage
    assign prod  = (2*QW)'(p_prev) * (2*QW)'(a_prev);
    assign p_new = prod[2*QW-1:16];
    assign act   = (ORD_W'(i) < n) && !kill_prev;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[i] <= a_prev;
        if (act) begin
          p_r[i]    <= p_new[QW-1:0];
          kill_r[i] <= |p_new[QW+15:QW];
        end else begin
          p_r[i]    <= p_prev;
          kill_r[i] <= kill_prev;
        end
      end
    end
  end

  assign out_valid = vld_r[MAX_ORDER-1];
  assign out_p     = p_r[MAX_ORDER-1];
  assign out_kill  = kill_r[MAX_ORDER-1];

endmodule
